>>> hdl/three_level_priority_queue_with_cancel_assert.svh
// ----------------------------------------------------------------------------
// three_level_priority_queue_with_cancel assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_WITH_CANCEL_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_WITH_CANCEL_ASSERT_SVH

`ifndef SYNTHESIS
`define TLPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("three_level_priority_queue_with_cancel: assertion failed");
`define TLPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("three_level_priority_queue_with_cancel: assertion failed");
`else
`define TLPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg
// shared widths, codes and chain control type of the priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpq_pkg;

   localparam int ID_W         = 16;
   localparam int SEV_W        = 2;
   localparam int AGE_W        = 8;
   localparam int STAT_W       = 3;
   localparam int CMD_W        = 2;
   localparam int CAPACITY_DEF = 64;
   localparam int ID_BITS_DEF  = 16;

   localparam logic [SEV_W-1:0] SEV_SEVERE = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_INFO   = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic step;
      logic drop;
      logic load;
   } chain_ctl_type;

endpackage

>>> hdl/tlpq_cell.sv
// ----------------------------------------------------------------------------
// tlpq_cell
// one cell: loads or holds an entry, takes the next or head entry on a step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpq_cell #(
   parameter int KEY_W = tlpq_pkg::ID_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlpq_pkg::chain_ctl_type       ctl,
   input  logic                          tail_sel,
   input  logic                          load_sel,
   input  logic                          nxt_valid,
   input  logic [KEY_W-1:0]              nxt_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    nxt_sev,
   input  logic [tlpq_pkg::AGE_W-1:0]    nxt_age,
   input  logic [KEY_W-1:0]              head_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    head_sev,
   input  logic [tlpq_pkg::AGE_W-1:0]    head_age,
   input  logic [KEY_W-1:0]              new_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    new_sev,
   input  logic [tlpq_pkg::AGE_W-1:0]    new_age,
   output logic                          cell_valid,
   output logic [KEY_W-1:0]              cell_id,
   output logic [tlpq_pkg::SEV_W-1:0]    cell_sev,
   output logic [tlpq_pkg::AGE_W-1:0]    cell_age
);

   logic                       valid_ff, valid_in;
   logic [KEY_W-1:0]           id_ff, id_in;
   logic [tlpq_pkg::SEV_W-1:0] sev_ff, sev_in;
   logic [tlpq_pkg::AGE_W-1:0] age_ff, age_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      sev_in   = sev_ff;
      age_in   = age_ff;
      if (ctl.load && load_sel) begin
         valid_in = 1'b1;
         id_in    = new_id;
         sev_in   = new_sev;
         age_in   = new_age;
      end else if (ctl.step) begin
         if (tail_sel && !ctl.drop) begin
            valid_in = 1'b1;
            id_in    = head_id;
            sev_in   = head_sev;
            age_in   = head_age;
         end else begin
            valid_in = nxt_valid;
            id_in    = nxt_id;
            sev_in   = nxt_sev;
            age_in   = nxt_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      sev_ff <= sev_in;
      age_ff <= age_in;
   end

   assign cell_valid = valid_ff;
   assign cell_id    = id_ff;
   assign cell_sev   = sev_ff;
   assign cell_age   = age_ff;

endmodule

>>> hdl/tlpq_ctrl.sv
// ----------------------------------------------------------------------------
// tlpq_ctrl
// command sequencer: walks the chain head, tracks matches and the best
// peek candidate, and drives the registered response transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "three_level_priority_queue_with_cancel_assert.svh"

module tlpq_ctrl #(
   parameter  int CAPACITY = tlpq_pkg::CAPACITY_DEF,
   parameter  int KEY_W    = tlpq_pkg::ID_W,
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tlpq_pkg::CMD_W-1:0]    req_command,
   input  logic [tlpq_pkg::ID_W-1:0]     req_entry_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    req_severity,
   input  logic [tlpq_pkg::AGE_W-1:0]    req_age,
   input  logic                          head_valid,
   input  logic [KEY_W-1:0]              head_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    head_sev,
   input  logic [tlpq_pkg::AGE_W-1:0]    head_age,
   output tlpq_pkg::chain_ctl_type       ctl,
   output logic [CW-1:0]                 count,
   output logic [KEY_W-1:0]              new_id,
   output logic [tlpq_pkg::SEV_W-1:0]    new_sev,
   output logic [tlpq_pkg::AGE_W-1:0]    new_age,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlpq_pkg::STAT_W-1:0]   rsp_status,
   output logic [tlpq_pkg::ID_W-1:0]     rsp_id_out,
   output logic [tlpq_pkg::SEV_W-1:0]    rsp_severity_out,
   output logic [tlpq_pkg::AGE_W-1:0]    rsp_age_out,
   output logic                          rsp_nonempty
);

   localparam int IdW = tlpq_pkg::ID_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   tlpq_pkg::cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]            key_ff, key_in;
   logic [tlpq_pkg::SEV_W-1:0]  sev_ff, sev_in;
   logic [tlpq_pkg::AGE_W-1:0]  age_ff, age_in;
   logic [CW-1:0]               steps_ff, steps_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        found_ff, found_in;
   logic [tlpq_pkg::AGE_W-1:0]  hit_age_ff, hit_age_in;
   logic                        best_valid_ff, best_valid_in;
   logic [KEY_W-1:0]            best_id_ff, best_id_in;
   logic [tlpq_pkg::SEV_W-1:0]  best_sev_ff, best_sev_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tlpq_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [IdW-1:0]              rsp_id_ff, rsp_id_in;
   logic [tlpq_pkg::SEV_W-1:0]  rsp_sev_ff, rsp_sev_in;
   logic [tlpq_pkg::AGE_W-1:0]  rsp_age_ff, rsp_age_in;
   logic                        rsp_nonempty_ff, rsp_nonempty_in;

   logic head_hit;
   logic out_free;

   assign head_hit = head_valid && (head_id == key_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctl.step = (state_ff == S_WALK);
      ctl.drop = (state_ff == S_WALK) && (cmd_ff == tlpq_pkg::CMD_REMOVE) && head_hit;
      ctl.load = (state_ff == S_DONE) && out_free && (cmd_ff == tlpq_pkg::CMD_ADD)
                 && !found_ff && (count_ff != CW'(CAPACITY));
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      sev_in          = sev_ff;
      age_in          = age_ff;
      steps_in        = steps_ff;
      count_in        = count_ff;
      found_in        = found_ff;
      hit_age_in      = hit_age_ff;
      best_valid_in   = best_valid_ff;
      best_id_in      = best_id_ff;
      best_sev_in     = best_sev_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_sev_in      = rsp_sev_ff;
      rsp_age_in      = rsp_age_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = tlpq_pkg::cmd_type'(req_command);
               key_in        = req_entry_id[KEY_W-1:0];
               sev_in        = (req_severity > tlpq_pkg::SEV_SEVERE) ?
                               tlpq_pkg::SEV_SEVERE : req_severity;
               age_in        = req_age;
               found_in      = 1'b0;
               best_valid_in = 1'b0;
               steps_in      = count_ff;
               state_in      = (count_ff == '0) ? S_DONE : S_WALK;
            end
         end
         S_WALK: begin
            if (head_hit) begin
               found_in   = 1'b1;
               hit_age_in = head_age;
            end
            if ((cmd_ff == tlpq_pkg::CMD_PEEK) && (!best_valid_ff || (head_sev > best_sev_ff)))
            begin
               best_valid_in = 1'b1;
               best_id_in    = head_id;
               best_sev_in   = head_sev;
            end
            if (ctl.drop) begin
               count_in = count_ff - CW'(1);
            end
            steps_in = steps_ff - CW'(1);
            if (steps_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in        = S_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = tlpq_pkg::ST_OK;
               rsp_id_in       = IdW'(key_ff);
               rsp_sev_in      = '0;
               rsp_age_in      = '0;
               rsp_nonempty_in = (count_ff != '0);
               case (cmd_ff)
                  tlpq_pkg::CMD_ADD: begin
                     if (found_ff) begin
                        rsp_status_in = tlpq_pkg::ST_DUP;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        rsp_status_in = tlpq_pkg::ST_FULL;
                     end else begin
                        count_in        = count_ff + CW'(1);
                        rsp_nonempty_in = 1'b1;
                     end
                  end
                  tlpq_pkg::CMD_INFO: begin
                     if (found_ff) begin
                        rsp_age_in = hit_age_ff;
                     end else begin
                        rsp_status_in = tlpq_pkg::ST_NOTFOUND;
                     end
                  end
                  tlpq_pkg::CMD_PEEK: begin
                     if (best_valid_ff) begin
                        rsp_id_in  = IdW'(best_id_ff);
                        rsp_sev_in = best_sev_ff;
                     end else begin
                        rsp_status_in = tlpq_pkg::ST_EMPTY;
                        rsp_id_in     = '0;
                     end
                  end
                  tlpq_pkg::CMD_REMOVE: begin
                     if (!found_ff) begin
                        rsp_status_in = tlpq_pkg::ST_NOTFOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = tlpq_pkg::ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      sev_ff          <= sev_in;
      age_ff          <= age_in;
      steps_ff        <= steps_in;
      found_ff        <= found_in;
      hit_age_ff      <= hit_age_in;
      best_valid_ff   <= best_valid_in;
      best_id_ff      <= best_id_in;
      best_sev_ff     <= best_sev_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_sev_ff      <= rsp_sev_in;
      rsp_age_ff      <= rsp_age_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign count            = count_ff;
   assign new_id           = key_ff;
   assign new_sev          = sev_ff;
   assign new_age          = age_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_id_out       = rsp_id_ff;
   assign rsp_severity_out = rsp_sev_ff;
   assign rsp_age_out      = rsp_age_ff;
   assign rsp_nonempty     = rsp_nonempty_ff;

   // ids are unique in the store, so a removal hits at most once per walk
   `TLPQ_ASSERT_IMP(a_single_drop, clock, reset, ctl.drop, !found_ff)
   `TLPQ_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `TLPQ_ASSERT_NXT(a_load_ok, clock, reset, ctl.load, rsp_valid_ff && rsp_status_ff == tlpq_pkg::ST_OK)

endmodule

>>> hdl/three_level_priority_queue_with_cancel.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue_with_cancel
// a request is registered, then the sequencer walks any entries in the chain,
// rotating one cell past the head per cycle, and registers the response once
// the output is free; req_stall holds off a new command until it is issued
// reset: synchronous; clears all cell valid bits, the entry count and the
// sequencer; no clearing pass, the queue is ready on the first cycle after
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "three_level_priority_queue_with_cancel_assert.svh"

module three_level_priority_queue_with_cancel #(
   parameter int CAPACITY = tlpq_pkg::CAPACITY_DEF,
   parameter int ID_BITS  = tlpq_pkg::ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tlpq_pkg::CMD_W-1:0]    req_command,
   input  logic [tlpq_pkg::ID_W-1:0]     req_entry_id,
   input  logic [tlpq_pkg::SEV_W-1:0]    req_severity,
   input  logic [tlpq_pkg::AGE_W-1:0]    req_age,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlpq_pkg::STAT_W-1:0]   rsp_status,
   output logic [tlpq_pkg::ID_W-1:0]     rsp_id_out,
   output logic [tlpq_pkg::SEV_W-1:0]    rsp_severity_out,
   output logic [tlpq_pkg::AGE_W-1:0]    rsp_age_out,
   output logic                          rsp_nonempty
);

   localparam int KeyW = (ID_BITS < tlpq_pkg::ID_W) ? ID_BITS : tlpq_pkg::ID_W;
   localparam int CW   = $clog2(CAPACITY + 1);

   tlpq_pkg::chain_ctl_type    ctl;
   logic [CW-1:0]              count;
   logic [KeyW-1:0]            new_id;
   logic [tlpq_pkg::SEV_W-1:0] new_sev;
   logic [tlpq_pkg::AGE_W-1:0] new_age;

   logic [CAPACITY-1:0]        cell_valid;
   logic [KeyW-1:0]            cell_id  [CAPACITY];
   logic [tlpq_pkg::SEV_W-1:0] cell_sev [CAPACITY];
   logic [tlpq_pkg::AGE_W-1:0] cell_age [CAPACITY];

   tlpq_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_W    (KeyW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_entry_id     (req_entry_id),
      .req_severity     (req_severity),
      .req_age          (req_age),
      .head_valid       (cell_valid[0]),
      .head_id          (cell_id[0]),
      .head_sev         (cell_sev[0]),
      .head_age         (cell_age[0]),
      .ctl              (ctl),
      .count            (count),
      .new_id           (new_id),
      .new_sev          (new_sev),
      .new_age          (new_age),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_id_out       (rsp_id_out),
      .rsp_severity_out (rsp_severity_out),
      .rsp_age_out      (rsp_age_out),
      .rsp_nonempty     (rsp_nonempty)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                       nxt_valid;
      logic [KeyW-1:0]            nxt_id;
      logic [tlpq_pkg::SEV_W-1:0] nxt_sev;
      logic [tlpq_pkg::AGE_W-1:0] nxt_age;

      if (i == CAPACITY - 1) begin : g_end
         assign nxt_valid = 1'b0;
         assign nxt_id    = '0;
         assign nxt_sev   = '0;
         assign nxt_age   = '0;
      end else begin : g_link
         assign nxt_valid = cell_valid[i+1];
         assign nxt_id    = cell_id[i+1];
         assign nxt_sev   = cell_sev[i+1];
         assign nxt_age   = cell_age[i+1];
      end

      tlpq_cell #(
         .KEY_W (KeyW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .tail_sel   (count == CW'(i + 1)),
         .load_sel   (count == CW'(i)),
         .nxt_valid  (nxt_valid),
         .nxt_id     (nxt_id),
         .nxt_sev    (nxt_sev),
         .nxt_age    (nxt_age),
         .head_id    (cell_id[0]),
         .head_sev   (cell_sev[0]),
         .head_age   (cell_age[0]),
         .new_id     (new_id),
         .new_sev    (new_sev),
         .new_age    (new_age),
         .cell_valid (cell_valid[i]),
         .cell_id    (cell_id[i]),
         .cell_sev   (cell_sev[i]),
         .cell_age   (cell_age[i])
      );

      // valid cells always form a prefix of the chain
      if (i < CAPACITY - 1) begin : g_chk
         `TLPQ_ASSERT_IMP(a_prefix, clock, reset, cell_valid[i+1], cell_valid[i])
      end
   end

   `TLPQ_ASSERT_IMP(a_count_match, clock, reset, 1'b1, $countones(cell_valid) == int'(count))
   `TLPQ_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

endmodule
